### sv/fca_pkg.sv
// Shared types and constants of the chain allocator.
package fca_pkg;

    localparam int NUM_BLOCKS = 1024;
    localparam int BLK_W      = 10;

    typedef logic [BLK_W-1:0] t_blk;

    typedef enum logic [1:0] {
        FN_ALLOC  = 2'd0,
        FN_RESIZE = 2'd1,
        FN_FREE   = 2'd2,
        FN_READ   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_NO_ROOM = 2'd1,
        STS_INVALID = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_WALK,
        S_FREE,
        S_POP,
        S_TAIL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0] func;
        t_blk       block;
        t_blk       block_count;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        t_blk       block_out;
        t_blk       free_count;
    } t_out_item;

    // One entry of the link table: in-use flag and next link.
    typedef struct packed {
        logic used;
        t_blk link;
    } t_link_ent;

    typedef struct packed {
        logic      we;
        t_blk      waddr;
        t_link_ent wdata;
        t_blk      raddr;
    } t_lm_req;

    typedef struct packed {
        logic we;
        t_blk waddr;
        t_blk wdata;
        t_blk raddr;
    } t_sk_req;

endpackage

### sv/fca_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module fca_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/fca_ctrl.sv
// Sequencer that walks, builds and frees chains through the link and stack memories.
module fca_ctrl import fca_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    output t_lm_req   o_lm_req,
    input  t_link_ent i_lm_rdata,
    output t_sk_req   o_sk_req,
    input  t_blk      i_sk_rdata
);

    t_state    r_state, n_state;
    t_func     r_func, n_func;
    t_blk      r_blk, n_blk;
    t_blk      r_cnt, n_cnt;
    t_blk      r_a, n_a;
    t_blk      r_cur, n_cur;
    t_blk      r_len, n_len;
    logic      r_first, n_first;
    t_blk      r_ft, n_ft;
    t_blk      r_left, n_left;
    logic      r_pend, n_pend;
    t_blk      r_prev, n_prev;
    logic      r_has_prev, n_has_prev;
    t_blk      r_start, n_start;
    t_blk      r_init, n_init;
    t_status   r_status, n_status;
    t_blk      r_bout, n_bout;
    logic      r_fwd_hit, n_fwd_hit;
    t_link_ent r_fwd_data, n_fwd_data;
    logic      r_ovalid, n_ovalid;
    t_out_item r_out, n_out;

    t_lm_req   lm;
    t_sk_req   sk;
    t_link_ent d;
    logic      in_acc;
    logic      d_live;
    t_blk      len1;
    logic      walk_more;
    t_blk      need;
    logic      need_fail;
    logic      alloc_fail;
    logic      out_free;

    // A read that hits the entry written in the same cycle sees the new value.
    assign d          = r_fwd_hit ? r_fwd_data : i_lm_rdata;
    assign d_live     = (r_a != '0) && d.used;
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign len1       = r_len + 1'b1;
    assign walk_more  = len1 < r_cnt;
    assign need       = r_cnt - r_len;
    assign need_fail  = need >= r_ft;
    assign alloc_fail = i_in_item.block_count >= r_ft;
    assign out_free   = !r_ovalid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (r_init == t_blk'(NUM_BLOCKS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    unique case (t_func'(i_in_item.func))
                        FN_ALLOC: begin
                            if (i_in_item.block_count == '0 || alloc_fail) n_state = S_DONE;
                            else n_state = S_POP;
                        end
                        FN_RESIZE: begin
                            if (i_in_item.block_count == '0) n_state = S_DONE;
                            else n_state = S_WALK;
                        end
                        FN_FREE: n_state = S_FREE;
                        FN_READ: n_state = S_READ;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_READ: n_state = S_DONE;
            S_WALK: begin
                if (!d_live) begin
                    if (r_first || need_fail) n_state = S_DONE;
                    else n_state = S_POP;
                end else if (!walk_more) begin
                    n_state = S_FREE;
                end
            end
            S_FREE: begin
                if (!d_live) n_state = S_DONE;
            end
            S_POP: begin
                if (r_left == '0 && r_pend) n_state = S_TAIL;
            end
            S_TAIL: n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory ports.
    always_comb begin
        lm         = '0;
        sk         = '0;
        n_func     = r_func;
        n_blk      = r_blk;
        n_cnt      = r_cnt;
        n_a        = r_a;
        n_cur      = r_cur;
        n_len      = r_len;
        n_first    = r_first;
        n_ft       = r_ft;
        n_left     = r_left;
        n_pend     = r_pend;
        n_prev     = r_prev;
        n_has_prev = r_has_prev;
        n_start    = r_start;
        n_init     = r_init;
        n_status   = r_status;
        n_bout     = r_bout;
        n_ovalid   = r_ovalid;
        n_out      = r_out;

        if (r_ovalid && !i_out_stall) n_ovalid = 1'b0;

        unique case (r_state)
            S_INIT: begin
                lm.we    = 1'b1;
                lm.waddr = r_init;
                lm.wdata = '0;
                sk.we    = 1'b1;
                sk.waddr = r_init;
                sk.wdata = ~r_init;
                n_init   = r_init + 1'b1;
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_func     = t_func'(i_in_item.func);
                    n_blk      = i_in_item.block;
                    n_cnt      = i_in_item.block_count;
                    n_a        = i_in_item.block;
                    n_len      = '0;
                    n_first    = 1'b1;
                    n_left     = i_in_item.block_count;
                    n_pend     = 1'b0;
                    n_has_prev = 1'b0;
                    n_status   = STS_OK;
                    n_bout     = '0;
                    lm.raddr   = i_in_item.block;
                    if (i_in_item.block_count == '0 &&
                        (t_func'(i_in_item.func) == FN_ALLOC ||
                         t_func'(i_in_item.func) == FN_RESIZE)) begin
                        n_status = STS_INVALID;
                    end else if (t_func'(i_in_item.func) == FN_ALLOC && alloc_fail) begin
                        n_status = STS_NO_ROOM;
                    end
                end
            end
            S_READ: begin
                n_bout = d.link;
            end
            S_WALK: begin
                if (!d_live) begin
                    if (r_first) begin
                        n_status = STS_INVALID;
                    end else if (need_fail) begin
                        n_status = STS_NO_ROOM;
                    end else begin
                        n_left     = need;
                        n_prev     = r_cur;
                        n_has_prev = 1'b1;
                        n_pend     = 1'b0;
                    end
                end else begin
                    n_cur    = r_a;
                    n_first  = 1'b0;
                    n_len    = len1;
                    lm.raddr = d.link;
                    n_a      = d.link;
                    if (!walk_more) begin
                        // Cut the chain here; the tail is freed next.
                        lm.we          = 1'b1;
                        lm.waddr       = r_a;
                        lm.wdata.used  = 1'b1;
                        lm.wdata.link  = '0;
                    end
                end
            end
            S_FREE: begin
                if (d_live) begin
                    lm.we    = 1'b1;
                    lm.waddr = r_a;
                    lm.wdata = '0;
                    lm.raddr = d.link;
                    n_a      = d.link;
                    sk.we    = 1'b1;
                    sk.waddr = r_ft;
                    sk.wdata = r_a;
                    n_ft     = r_ft + 1'b1;
                    n_first  = 1'b0;
                end else begin
                    n_status = r_first ? STS_INVALID : STS_OK;
                    n_bout   = (r_func == FN_RESIZE && !r_first) ? r_blk : '0;
                end
            end
            S_POP: begin
                n_pend = 1'b0;
                if (r_left != '0) begin
                    sk.raddr = r_ft - 1'b1;
                    n_ft     = r_ft - 1'b1;
                    n_left   = r_left - 1'b1;
                    n_pend   = 1'b1;
                end
                if (r_pend) begin
                    if (r_has_prev) begin
                        lm.we         = 1'b1;
                        lm.waddr      = r_prev;
                        lm.wdata.used = 1'b1;
                        lm.wdata.link = i_sk_rdata;
                    end else begin
                        n_start = i_sk_rdata;
                    end
                    n_prev     = i_sk_rdata;
                    n_has_prev = 1'b1;
                end
            end
            S_TAIL: begin
                lm.we         = 1'b1;
                lm.waddr      = r_prev;
                lm.wdata.used = 1'b1;
                lm.wdata.link = '0;
                n_status      = STS_OK;
                n_bout        = (r_func == FN_ALLOC) ? r_start : r_blk;
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid         = 1'b1;
                    n_out.status     = r_status;
                    n_out.block_out  = r_bout;
                    n_out.free_count = r_ft;
                end
            end
            default: ;
        endcase

        n_fwd_hit  = lm.we && (lm.waddr == lm.raddr);
        n_fwd_data = lm.wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_init    <= '0;
            r_ft      <= t_blk'(NUM_BLOCKS - 1);
            r_ovalid  <= 1'b0;
            r_fwd_hit <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_init    <= n_init;
            r_ft      <= n_ft;
            r_ovalid  <= n_ovalid;
            r_fwd_hit <= n_fwd_hit;
            r_pend    <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_blk      <= n_blk;
        r_cnt      <= n_cnt;
        r_a        <= n_a;
        r_cur      <= n_cur;
        r_len      <= n_len;
        r_first    <= n_first;
        r_left     <= n_left;
        r_prev     <= n_prev;
        r_has_prev <= n_has_prev;
        r_start    <= n_start;
        r_status   <= n_status;
        r_bout     <= n_bout;
        r_fwd_data <= n_fwd_data;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;
    assign o_lm_req    = lm;
    assign o_sk_req    = sk;

endmodule

### sv/fat_chain_allocator.sv
// Top level of the chain allocator: sequencer plus link-table and free-stack memories.
//
// The block keeps a 1024-entry link table (next link and in-use flag per block) and a
// LIFO stack of free blocks, both in single-port-write synchronous RAMs. After reset a
// clearing pass fills both memories, and no item is taken until it ends. One item is
// worked at a time. An allocate of N blocks pops them from the stack one per cycle; a
// resize that keeps C blocks walks them and frees a tail of T, and one that appends K
// blocks to a chain of L blocks walks the L blocks and pops the K; a free visits each
// block of the chain in turn. The rate is set by the one read port of each memory,
// which serves one link or one pop per cycle. A finished result waits in an output
// register while the next item is accepted.
module fat_chain_allocator import fca_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_lm_req   lm_req;
    t_sk_req   sk_req;
    t_link_ent lm_rdata;
    t_blk      sk_rdata;

    fca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .o_lm_req    (lm_req),
        .i_lm_rdata  (lm_rdata),
        .o_sk_req    (sk_req),
        .i_sk_rdata  (sk_rdata)
    );

    fca_ram #(
        .WIDTH ($bits(t_link_ent)),
        .DEPTH (NUM_BLOCKS)
    ) u_link_mem (
        .i_clk   (i_clk),
        .i_we    (lm_req.we),
        .i_waddr (lm_req.waddr),
        .i_wdata (lm_req.wdata),
        .i_raddr (lm_req.raddr),
        .o_rdata (lm_rdata)
    );

    fca_ram #(
        .WIDTH (BLK_W),
        .DEPTH (NUM_BLOCKS)
    ) u_stack_mem (
        .i_clk   (i_clk),
        .i_we    (sk_req.we),
        .i_waddr (sk_req.waddr),
        .i_wdata (sk_req.wdata),
        .i_raddr (sk_req.raddr),
        .o_rdata (sk_rdata)
    );

endmodule

### dv/fat_chain_allocator_checker.sv
// Checker of the chain allocator: link-table predictor and result comparison.
module fat_chain_allocator_checker import fca_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);

    int unsigned link_tbl [NUM_BLOCKS];
    bit          used_tbl [NUM_BLOCKS];
    int unsigned free_stk [NUM_BLOCKS];
    int unsigned free_tot;
    t_out_item   expected_q [$];

    function automatic bit live(int unsigned b);
        return b != 0 && b < NUM_BLOCKS && used_tbl[b];
    endfunction

    function automatic int unsigned live_next(int unsigned b);
        return live(link_tbl[b]) ? link_tbl[b] : 0;
    endfunction

    function automatic int unsigned take_block();
        int unsigned b;
        free_tot--;
        b = free_stk[free_tot] % NUM_BLOCKS;
        used_tbl[b] = 1'b1;
        link_tbl[b] = 0;
        return b;
    endfunction

    function automatic void give_block(int unsigned b);
        used_tbl[b] = 1'b0;
        link_tbl[b] = 0;
        if (free_tot < NUM_BLOCKS) begin
            free_stk[free_tot] = b;
            free_tot++;
        end
    endfunction

    function automatic void release_chain(int unsigned b);
        int unsigned steps;
        int unsigned nx;
        steps = 0;
        while (live(b) && steps < NUM_BLOCKS) begin
            nx = live_next(b);
            give_block(b);
            b = nx;
            steps++;
        end
    endfunction

    function automatic t_out_item predict_result(t_in_item it);
        t_out_item   r;
        int unsigned blk, cnt, cur, len, need, nb;
        t_status     sts;
        blk = it.block;
        cnt = it.block_count;
        sts = STS_OK;
        r.block_out = '0;
        case (t_func'(it.func))
            FN_ALLOC: begin
                if (cnt == 0) sts = STS_INVALID;
                else if (cnt >= free_tot) sts = STS_NO_ROOM;
                else begin
                    r.block_out = t_blk'(take_block());
                    cur = r.block_out;
                    for (int unsigned i = 1; i < cnt; i++) begin
                        nb = take_block();
                        link_tbl[cur] = nb;
                        cur = nb;
                    end
                end
            end
            FN_RESIZE: begin
                if (cnt == 0 || !live(blk)) sts = STS_INVALID;
                else begin
                    cur = blk;
                    len = 1;
                    while (len < cnt && live_next(cur) != 0) begin
                        cur = live_next(cur);
                        len++;
                    end
                    if (len == cnt) begin
                        nb = live_next(cur);
                        link_tbl[cur] = 0;
                        release_chain(nb);
                        r.block_out = t_blk'(blk);
                    end else begin
                        need = cnt - len;
                        if (need >= free_tot) sts = STS_NO_ROOM;
                        else begin
                            for (int unsigned i = 0; i < need; i++) begin
                                nb = take_block();
                                link_tbl[cur] = nb;
                                cur = nb;
                            end
                            r.block_out = t_blk'(blk);
                        end
                    end
                end
            end
            FN_FREE: begin
                if (!live(blk)) sts = STS_INVALID;
                else release_chain(blk);
            end
            default: r.block_out = t_blk'(link_tbl[blk]);
        endcase
        r.status = sts;
        r.free_count = t_blk'(free_tot);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                link_tbl[i] = 0;
                used_tbl[i] = 1'b0;
                free_stk[i] = (i + 1 < NUM_BLOCKS) ? NUM_BLOCKS - 1 - i : 0;
            end
            free_tot = NUM_BLOCKS - 1;
            expected_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                expected_q = {expected_q, predict_result(i_in_item)};
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result with none expected: %p", $time, i_out_item);
                    o_fail_count++;
                end else begin
                    t_out_item e;
                    e = expected_q.pop_front();
                    if (e.status != i_out_item.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, i_out_item.status);
                        o_fail_count++;
                    end
                    if (e.block_out != i_out_item.block_out) begin
                        $display("%0t: block_out expected %0d actual %0d",
                                 $time, e.block_out, i_out_item.block_out);
                        o_fail_count++;
                    end
                    if (e.free_count != i_out_item.free_count) begin
                        $display("%0t: free_count expected %0d actual %0d",
                                 $time, e.free_count, i_out_item.free_count);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

### dv/fat_chain_allocator_test.sv
// Testbench top of the chain allocator: clock, reset, stimulus and verdict.
module fat_chain_allocator_test;
    import fca_pkg::*;

    localparam int CYCLE_LIMIT = 10000000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;
    int        fail_count;
    int        pending;
    int        cycles = 0;
    bit        steady = 1'b0;
    t_blk      heads [$];
    t_func     issued_q [$];

    fat_chain_allocator u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    fat_chain_allocator_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** fat_chain_allocator: FAILED **");
            $finish;
        end
    end

    always @(posedge clk) begin
        out_stall <= steady ? 1'b0 : ($urandom_range(99) < 31);
    end

    // New chain heads are learned from allocate results to steer later items.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall && issued_q.size() != 0) begin
            if (issued_q.pop_front() == FN_ALLOC && out_item.status == STS_OK)
                heads = {heads, out_item.block_out};
        end
    end

    task automatic send_item(t_func fn, int unsigned blk, int unsigned cnt);
        in_valid <= 1'b1;
        in_item <= '{func: fn, block: t_blk'(blk), block_count: t_blk'(cnt)};
        do @(posedge clk); while (in_stall);
        issued_q = {issued_q, fn};
        if (!steady && $urandom_range(99) < 31) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic int unsigned pick_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(24, 1);
        if (r < 95) return $urandom_range(200, 1);
        return $urandom_range(1023, 1);
    endfunction

    function automatic int unsigned pick_head();
        if (heads.size() == 0) return $urandom_range(1023);
        return heads[$urandom_range(heads.size() - 1)];
    endfunction

    initial begin
        int unsigned h, r, idx;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_item(FN_ALLOC, 0, 0);
        send_item(FN_ALLOC, 0, 1023);
        send_item(FN_ALLOC, 1023, 1);
        send_item(FN_ALLOC, 0, 6);
        send_item(FN_READ, 0, 0);
        send_item(FN_READ, 1023, 1023);
        drain();
        h = pick_head();
        send_item(FN_READ, h, 0);
        send_item(FN_RESIZE, h, 0);
        send_item(FN_RESIZE, 0, 4);
        send_item(FN_RESIZE, 1023, 4);
        send_item(FN_RESIZE, h, 12);
        send_item(FN_RESIZE, h, 3);
        send_item(FN_RESIZE, h, 3);
        send_item(FN_RESIZE, h, 1022);
        send_item(FN_FREE, h, 0);
        send_item(FN_FREE, h, 0);
        send_item(FN_FREE, 0, 0);
        send_item(FN_RESIZE, h, 2);
        send_item(FN_READ, h, 0);
        send_item(FN_ALLOC, 682, 341);
        drain();
        heads.delete();

        for (int n = 0; n < 750; n++) begin
            steady = (n >= 300 && n < 400);
            if (n == 500) drain();
            r = $urandom_range(99);
            if (r < 5) begin
                send_item(t_func'($urandom_range(3)), $urandom_range(1023),
                          $urandom_range(1023));
            end else if (heads.size() < 3 || r < 35) begin
                send_item(FN_ALLOC, $urandom_range(1023), pick_count());
            end else if (r < 60) begin
                send_item(FN_RESIZE, pick_head(), pick_count());
            end else if (r < 80 || heads.size() > 20) begin
                idx = $urandom_range(heads.size() - 1);
                h = heads[idx];
                heads.delete(idx);
                send_item(FN_FREE, h, $urandom_range(1023));
            end else begin
                send_item(FN_READ, (r & 1) ? pick_head() : $urandom_range(1023),
                          $urandom_range(1023));
            end
        end
        steady = 1'b0;
        drain();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("** fat_chain_allocator: PASSED **");
        else
            $display("** fat_chain_allocator: FAILED **");
        $finish;
    end

endmodule
